>>> rtl/crc16_word_swapped_macros.svh
// Assertion helpers for the RTL, used by crc16_word_swapped.
`ifndef CRC16_WORD_SWAPPED_MACROS_SVH
`define CRC16_WORD_SWAPPED_MACROS_SVH

// Checked on every clock edge outside reset.
`define CRC16WS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CRC16WS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/crc16ws_pkg.sv
package crc16ws_pkg;

   localparam int CRC_WIDTH       = 16;
   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CRC_WIDTH-1:0] POLY_RESET = 16'h1021;
   localparam logic [CRC_WIDTH-1:0] INIT_RESET = 16'h0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_POLYNOMIAL    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDX_INITIAL_VALUE = 2'd1;

   typedef logic [CRC_WIDTH-1:0]  crc_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      crc_type polynomial;
      crc_type initial_value;
      logic    init_load;   // initial_value written this cycle
      crc_type init_data;   // value being written
   } cfg_type;

endpackage

>>> rtl/crc16_word_swapped.sv
// CRC-16 over a firmware image, one 16-bit word per request.
// Request channel (req_): data_word and last_word, taken when req_valid is
//   high and req_stall low. Bits 15..8 are folded first, then bits 7..0,
//   MSB-first with the programmed polynomial.
// Response channel (rsp_): one image CRC per image, sent for the word that
//   carries last_word; the running CRC then restarts from initial_value.
// Config channel (csr_): index 0 polynomial, 1 initial value; csr_ready is
//   always high. Writing the initial value also restarts the running CRC.
//   Other indexes are ignored. Write only while no image is in flight.
// Throughput: one word per cycle while req_stall is low; the fold of both
//   bytes (sixteen shift/XOR steps) sits between the request register and
//   the running CRC register, and also before the response register.
// Stall: a response held by rsp_stall stays in the output register; words
//   that are not last keep flowing. A further last word waits in the request
//   register and req_stall rises until the response is taken.
// Reset (synchronous, active high): both stages empty, polynomial 0x1021,
//   initial value and running CRC zero.
`include "crc16_word_swapped_macros.svh"

module crc16_word_swapped (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [15:0]                             req_data_word,
   input  logic                                    req_last_word,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [15:0]                             rsp_image_crc,
   // configuration channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [crc16ws_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                             csr_data
);

   crc16ws_pkg::cfg_type cfg;

   // request register
   logic                 in_valid_ff, in_valid_in;
   crc16ws_pkg::crc_type in_word_ff;
   logic                 in_last_ff;

   // running CRC and response register
   crc16ws_pkg::crc_type running_crc_ff, running_crc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   crc16ws_pkg::crc_type rsp_crc_ff, rsp_crc_in;

   crc16ws_pkg::crc_type crc_hi;
   crc16ws_pkg::crc_type crc_word;
   logic                 req_take;
   logic                 advance;
   logic                 load_rsp;

   crc16ws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // high byte first, then low byte
   crc16ws_byte_fold u_fold_hi (
      .crc_in     (running_crc_ff),
      .byte_in    (in_word_ff[15:8]),
      .polynomial (cfg.polynomial),
      .crc_out    (crc_hi)
   );

   crc16ws_byte_fold u_fold_lo (
      .crc_in     (crc_hi),
      .byte_in    (in_word_ff[7:0]),
      .polynomial (cfg.polynomial),
      .crc_out    (crc_word)
   );

   // A held word moves on unless it is a last word and the response slot is
   // full and stalled.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign load_rsp  = advance && in_last_ff;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // a write of the initial value restarts the image
      if (cfg.init_load) begin
         running_crc_in = cfg.init_data;
      end else if (load_rsp) begin
         running_crc_in = cfg.initial_value;
      end else if (advance) begin
         running_crc_in = crc_word;
      end else begin
         running_crc_in = running_crc_ff;
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_crc_in   = crc_word;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_crc_in   = rsp_crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         running_crc_ff <= crc16ws_pkg::INIT_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         running_crc_ff <= running_crc_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data_word;
         in_last_ff <= req_last_word;
      end
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_image_crc = rsp_crc_ff;

   `CRC16WS_ASSERT_RST(a_reset_empty,
      reset |=> !in_valid_ff && !rsp_valid_ff,
      "stages not empty after reset")
   `CRC16WS_ASSERT(a_mid_word_flows,
      (in_valid_ff && !in_last_ff) |-> !req_stall,
      "mid-image word stalled")
   `CRC16WS_ASSERT(a_stall_cause,
      (in_valid_ff && in_last_ff && req_stall) |-> (rsp_valid_ff && rsp_stall),
      "last word held without a stalled response")
   `CRC16WS_ASSERT(a_restart,
      (load_rsp && !cfg.init_load) |=> running_crc_ff == $past(cfg.initial_value),
      "running CRC not restarted after last word")

endmodule

>>> rtl/crc16ws_byte_fold.sv
// One byte into the CRC: XOR into the top, then eight MSB-first steps.
module crc16ws_byte_fold (
   input  crc16ws_pkg::crc_type  crc_in,
   input  crc16ws_pkg::byte_type byte_in,
   input  crc16ws_pkg::crc_type  polynomial,
   output crc16ws_pkg::crc_type  crc_out
);

   always_comb begin
      crc16ws_pkg::crc_type crc_v;
      crc_v = crc_in ^ {byte_in, {crc16ws_pkg::BYTE_WIDTH{1'b0}}};
      for (int k = 0; k < crc16ws_pkg::BYTE_WIDTH; k++) begin
         if (crc_v[crc16ws_pkg::CRC_WIDTH-1]) begin
            crc_v = {crc_v[crc16ws_pkg::CRC_WIDTH-2:0], 1'b0} ^ polynomial;
         end else begin
            crc_v = {crc_v[crc16ws_pkg::CRC_WIDTH-2:0], 1'b0};
         end
      end
      crc_out = crc_v;
   end

endmodule

>>> rtl/crc16ws_csr.sv
// Polynomial and initial value registers; unknown indexes are dropped.
module crc16ws_csr (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [crc16ws_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  crc16ws_pkg::crc_type                          csr_data,
   output crc16ws_pkg::cfg_type                          cfg
);

   crc16ws_pkg::crc_type poly_ff, poly_in;
   crc16ws_pkg::crc_type init_ff, init_in;
   logic                 wr_poly;
   logic                 wr_init;

   assign csr_ready = 1'b1;
   assign wr_poly   = csr_valid && (csr_index == crc16ws_pkg::CSR_IDX_POLYNOMIAL);
   assign wr_init   = csr_valid && (csr_index == crc16ws_pkg::CSR_IDX_INITIAL_VALUE);

   always_comb begin
      poly_in = wr_poly ? csr_data : poly_ff;
      init_in = wr_init ? csr_data : init_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crc16ws_pkg::POLY_RESET;
         init_ff <= crc16ws_pkg::INIT_RESET;
      end else begin
         poly_ff <= poly_in;
         init_ff <= init_in;
      end
   end

   always_comb begin
      cfg.polynomial    = poly_ff;
      cfg.initial_value = init_ff;
      cfg.init_load     = wr_init;
      cfg.init_data     = csr_data;
   end

endmodule
